// File: hw/rtl/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types, constants and helpers for the polygon support and bounds unit.
// ----------------------------------------------------------------------------
package psb_pkg;

	localparam int COORD_BITS      = 24;
	localparam int ROT_BITS        = 16;
	localparam int INDEX_BITS      = 3;
	localparam int MAX_CORNERS_DEF = 8;
	localparam int BOX_HALF        = 4096;
	localparam int ROT_FRAC        = 14;
	localparam int ROUND_HALF      = 8192;

	localparam logic signed [COORD_BITS-1:0] COORD_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_LO = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [2*COORD_BITS:0] WIDE_HI  =
		{{(COORD_BITS+2){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [2*COORD_BITS:0] WIDE_LO  =
		{{(COORD_BITS+2){1'b1}}, {(COORD_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_BOX     = 2'd0,
		OP_VERTEX  = 2'd1,
		OP_SUPPORT = 2'd2,
		OP_BOUNDS  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_SUPPORT = 2'd1,
		KIND_BOUNDS  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOX,
		ST_WALK,
		ST_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		op_t                          op;
		logic [INDEX_BITS-1:0]        vertex_index;
		logic                         last_vertex;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
		logic signed [ROT_BITS-1:0]   rot_cos;
		logic signed [ROT_BITS-1:0]   rot_sin;
		logic signed [COORD_BITS-1:0] shift_x;
		logic signed [COORD_BITS-1:0] shift_y;
	} psb_req_t;

	typedef struct packed {
		logic [1:0]                   result_kind;
		logic [INDEX_BITS-1:0]        support_index;
		logic signed [COORD_BITS-1:0] low_x;
		logic signed [COORD_BITS-1:0] low_y;
		logic signed [COORD_BITS-1:0] high_x;
		logic signed [COORD_BITS-1:0] high_y;
	} psb_rsp_t;

	function automatic logic signed [COORD_BITS-1:0] reset_corner_x(input int unsigned i);
		logic signed [COORD_BITS-1:0] v;
		case (i) inside
			32'd0, 32'd3: v = -COORD_BITS'(BOX_HALF);
			32'd1, 32'd2: v = COORD_BITS'(BOX_HALF);
			default:      v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] reset_corner_y(input int unsigned i);
		logic signed [COORD_BITS-1:0] v;
		case (i) inside
			32'd0, 32'd1: v = -COORD_BITS'(BOX_HALF);
			32'd2, 32'd3: v = COORD_BITS'(BOX_HALF);
			default:      v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [2*COORD_BITS:0] v
	);
		logic signed [COORD_BITS-1:0] r;
		if (v > WIDE_HI) begin
			r = COORD_HI;
		end else if (v < WIDE_LO) begin
			r = COORD_LO;
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/polygon_support_and_bounds.sv
// ----------------------------------------------------------------------------
// polygon_support_and_bounds
// Write vertex stores one entry; set box writes min(4,MAX_CORNERS) corners;
// support and bounds walk all count entries. One request is handled at a
// time: the next is taken in the cycle after the result is registered.
// Queries read the vertex memory one entry per cycle into a four-stage
// multiply, round, saturate and compare pipe.
// Reset: table reads as a box of half size 4096, count 4; no clearing pass.
// ----------------------------------------------------------------------------
module polygon_support_and_bounds #(
	parameter int MAX_CORNERS = psb_pkg::MAX_CORNERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  psb_pkg::psb_req_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output psb_pkg::psb_rsp_t  rsp
);
	import psb_pkg::*;

	localparam int IDX_W    = $clog2(MAX_CORNERS);
	localparam int CNT_W    = $clog2(MAX_CORNERS + 1);
	localparam int BOX_N    = (MAX_CORNERS < 4) ? MAX_CORNERS : 4;
	localparam int CB       = COORD_BITS;
	localparam int WA       = 2 * COORD_BITS + 1;
	localparam int WB       = COORD_BITS + ROT_BITS + 2;
	localparam int PB       = COORD_BITS + ROT_BITS;

	state_t state_q, state_d;

	logic [2*CB-1:0]       mem [MAX_CORNERS];
	logic [MAX_CORNERS-1:0] vld_q;
	logic [CNT_W-1:0]      count_q;
	logic [1:0]            box_cnt_q;
	logic [CNT_W-1:0]      iss_q;

	op_t                   op_q;
	logic signed [CB-1:0]  cx_q, cy_q, nx_q, ny_q, tx_q, ty_q;
	logic signed [ROT_BITS-1:0] cos_q, sin_q;

	logic                  accept;
	logic                  vtx_ok;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [2*CB-1:0]       wr_data;
	logic                  rd_en;
	logic                  issue_last;
	logic [IDX_W-1:0]      rd_addr;
	logic                  rsp_load;
	psb_rsp_t              rsp_d;

	logic                  v_s1, last_s1, vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [2*CB-1:0]       data_s1;
	logic signed [CB-1:0]  x1, y1, ka, kb;

	logic                  v_s2, last_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic signed [CB-1:0]  x_s2, y_s2;
	logic signed [2*CB-1:0] p0_s2, p1_s2;
	logic signed [PB-1:0]  p2_s2, p3_s2;

	logic                  v_s3, last_s3;
	logic [IDX_W-1:0]      idx_s3;
	logic signed [CB-1:0]  x_s3, y_s3;
	logic signed [WA-1:0]  sum_a_s3;
	logic signed [WB-1:0]  sum_b_s3;

	logic                  v_s4, last_s4;
	logic [IDX_W-1:0]      idx_s4;
	logic signed [CB-1:0]  x_s4, y_s4, vx_s4, vy_s4;
	logic signed [WA-1:0]  dot_s4;

	logic signed [WA-1:0]  acc_dot_q;
	logic [IDX_W-1:0]      acc_idx_q;
	logic signed [CB-1:0]  acc_lx_q, acc_ly_q, acc_hx_q, acc_hy_q;
	logic                  first_s4;

	logic                  rsp_valid_q;
	psb_rsp_t              rsp_q;

	assign accept  = req_valid && req_ready;
	assign vtx_ok  = 32'(req.vertex_index) < MAX_CORNERS;
	assign rd_addr = IDX_W'(iss_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = {req.coord_x, req.coord_y};
		rd_en      = 1'b0;
		issue_last = 1'b0;
		rsp_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req.op)
						OP_BOX: state_d = ST_BOX;
						OP_VERTEX: begin
							state_d = ST_FINISH;
							wr_en   = vtx_ok;
							wr_addr = IDX_W'(req.vertex_index);
						end
						OP_SUPPORT: state_d = ST_WALK;
						OP_BOUNDS:  state_d = ST_WALK;
					endcase
				end
			end
			ST_BOX: begin
				wr_en   = 1'b1;
				wr_addr = IDX_W'(box_cnt_q);
				wr_data = {((box_cnt_q == 2'd0 || box_cnt_q == 2'd3) ? nx_q : cx_q),
					((box_cnt_q == 2'd0 || box_cnt_q == 2'd1) ? ny_q : cy_q)};
				if (box_cnt_q == 2'(BOX_N - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_WALK: begin
				rd_en      = 1'b1;
				issue_last = (iss_q == count_q - CNT_W'(1));
				if (issue_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (v_s4 && last_s4) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				rsp_load = !rsp_valid_q || rsp_ready;
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control counters and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			count_q   <= CNT_W'(BOX_N);
			box_cnt_q <= '0;
			iss_q     <= '0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (accept) begin
				box_cnt_q <= '0;
				iss_q     <= '0;
				if (req.op == OP_VERTEX && vtx_ok && req.last_vertex) begin
					count_q <= CNT_W'(req.vertex_index) + CNT_W'(1);
				end
			end else begin
				if (state_q == ST_BOX) begin
					box_cnt_q <= box_cnt_q + 2'd1;
					if (box_cnt_q == 2'(BOX_N - 1)) begin
						count_q <= CNT_W'(BOX_N);
					end
				end
				if (rd_en) begin
					iss_q <= iss_q + CNT_W'(1);
				end
			end
		end
	end

	// request operands
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.op;
			cx_q  <= req.coord_x;
			cy_q  <= req.coord_y;
			nx_q  <= (req.coord_x == COORD_LO) ? COORD_HI : -req.coord_x;
			ny_q  <= (req.coord_y == COORD_LO) ? COORD_HI : -req.coord_y;
			cos_q <= req.rot_cos;
			sin_q <= req.rot_sin;
			tx_q  <= req.shift_x;
			ty_q  <= req.shift_y;
		end
	end

	// vertex memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
			vld_s1  <= vld_q[rd_addr];
			idx_s1  <= rd_addr;
			last_s1 <= issue_last;
		end
	end

	always_comb begin
		x1 = vld_s1 ? data_s1[2*CB-1:CB] : reset_corner_x(32'(idx_s1));
		y1 = vld_s1 ? data_s1[CB-1:0]    : reset_corner_y(32'(idx_s1));
		ka = (op_q == OP_SUPPORT) ? cx_q : CB'(cos_q);
		kb = (op_q == OP_SUPPORT) ? cy_q : CB'(sin_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// multiply, round, saturate
	always_ff @(posedge clk) begin
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;
		x_s2     <= x1;
		y_s2     <= y1;
		p0_s2    <= x1 * ka;
		p1_s2    <= y1 * kb;
		p2_s2    <= x1 * sin_q;
		p3_s2    <= y1 * cos_q;

		last_s3  <= last_s2;
		idx_s3   <= idx_s2;
		x_s3     <= x_s2;
		y_s3     <= y_s2;
		sum_a_s3 <= (op_q == OP_SUPPORT) ? (WA'(p0_s2) + WA'(p1_s2)) :
			(WA'(p0_s2) - WA'(p1_s2) + WA'(ROUND_HALF));
		sum_b_s3 <= WB'(p2_s2) + WB'(p3_s2) + WB'(ROUND_HALF);

		last_s4  <= last_s3;
		idx_s4   <= idx_s3;
		x_s4     <= x_s3;
		y_s4     <= y_s3;
		dot_s4   <= sum_a_s3;
		vx_s4    <= sat_coord(WA'(sum_a_s3 >>> ROT_FRAC) + WA'(tx_q));
		vy_s4    <= sat_coord(WA'(sum_b_s3 >>> ROT_FRAC) + WA'(ty_q));
	end

	assign first_s4 = (idx_s4 == '0);

	// accumulate
	always_ff @(posedge clk) begin
		if (v_s4) begin
			if (op_q == OP_SUPPORT) begin
				if (first_s4 || dot_s4 > acc_dot_q) begin
					acc_dot_q <= dot_s4;
					acc_idx_q <= idx_s4;
					acc_lx_q  <= x_s4;
					acc_ly_q  <= y_s4;
				end
			end else begin
				if (first_s4 || vx_s4 < acc_lx_q) acc_lx_q <= vx_s4;
				if (first_s4 || vy_s4 < acc_ly_q) acc_ly_q <= vy_s4;
				if (first_s4 || vx_s4 > acc_hx_q) acc_hx_q <= vx_s4;
				if (first_s4 || vy_s4 > acc_hy_q) acc_hy_q <= vy_s4;
			end
		end
	end

	always_comb begin
		rsp_d             = '0;
		rsp_d.result_kind = KIND_ACK;
		case (op_q)
			OP_SUPPORT: begin
				rsp_d.result_kind   = KIND_SUPPORT;
				rsp_d.support_index = INDEX_BITS'(acc_idx_q);
				rsp_d.low_x         = acc_lx_q;
				rsp_d.low_y         = acc_ly_q;
			end
			OP_BOUNDS: begin
				rsp_d.result_kind = KIND_BOUNDS;
				rsp_d.low_x       = acc_lx_q;
				rsp_d.low_y       = acc_ly_q;
				rsp_d.high_x      = acc_hx_q;
				rsp_d.high_y      = acc_hy_q;
			end
			default: rsp_d.result_kind = KIND_ACK;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && 32'(count_q) <= MAX_CORNERS)
		else $error("vertex count out of range");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_WAIT) |-> !wr_en)
		else $error("table write during a query walk");

	a_issue_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> iss_q < count_q)
		else $error("read issued beyond vertex count");

	a_last_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && last_s4) |-> state_q == ST_WAIT)
		else $error("last vertex drained outside wait");

	a_finish_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && last_s4) |=> state_q == ST_FINISH)
		else $error("query did not finish after last vertex");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives box loads, vertex writes, support and bounds queries into
// polygon_support_and_bounds and checks every reply against a vertex table
// tracked alongside the block. Directed corner cases come first, then random
// boxes and polygons followed by queries, mixed with stray writes, with random
// idling on both sides and one long reply back-pressure stretch.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import psb_pkg::*;

	localparam int ITEM_TARGET   = 1900;
	localparam int STALL_LIMIT   = 3000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 200;
	localparam int HOLD_AT       = 300;
	localparam int STEADY_FROM   = 700;
	localparam int STEADY_TO     = 1000;
	localparam int IDLE_PERCENT  = 17;
	localparam int REPORT_LIMIT  = 10;
	localparam int ROT_ONE       = 16384;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	psb_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	psb_rsp_t rsp;

	psb_req_t requests_to_send[$];
	psb_rsp_t replies_owed[$];

	logic signed [COORD_BITS-1:0] shape_x [MAX_CORNERS_DEF] =
		'{-BOX_HALF, BOX_HALF, BOX_HALF, -BOX_HALF, 0, 0, 0, 0};
	logic signed [COORD_BITS-1:0] shape_y [MAX_CORNERS_DEF] =
		'{-BOX_HALF, -BOX_HALF, BOX_HALF, BOX_HALF, 0, 0, 0, 0};
	int shape_count = 4;

	int sent_count     = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;
	int stall_cycles   = 0;
	int mismatch_count = 0;
	bit steady;

	assign steady = (sent_count >= STEADY_FROM && sent_count < STEADY_TO) || hold_left != 0;

	polygon_support_and_bounds DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
		logic signed [COORD_BITS-1:0] r;
		if (v > longint'(COORD_HI)) begin
			r = COORD_HI;
		end else if (v < longint'(COORD_LO)) begin
			r = COORD_LO;
		end else begin
			r = COORD_BITS'(v);
		end
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] negate_clamped(
		input logic signed [COORD_BITS-1:0] v
	);
		return clamp_coord(-longint'(v));
	endfunction

	// Apply one request to the tracked table and return the reply it owes.
	function automatic psb_rsp_t reply_for(input psb_req_t r);
		psb_rsp_t a;
		int       n;
		int       i;
		longint   dx, dy, dot, best;
		longint   px, py, rc, rs, vx, vy;
		longint   lo_x, lo_y, hi_x, hi_y;
		a = '0;
		n = shape_count;
		if (n < 1) n = 1;
		if (n > MAX_CORNERS_DEF) n = MAX_CORNERS_DEF;
		case (r.op)
			OP_BOX: begin
				shape_x[0] = negate_clamped(r.coord_x);
				shape_y[0] = negate_clamped(r.coord_y);
				shape_x[1] = r.coord_x;
				shape_y[1] = negate_clamped(r.coord_y);
				shape_x[2] = r.coord_x;
				shape_y[2] = r.coord_y;
				shape_x[3] = negate_clamped(r.coord_x);
				shape_y[3] = r.coord_y;
				shape_count = 4;
				a.result_kind = KIND_ACK;
			end
			OP_VERTEX: begin
				shape_x[r.vertex_index] = r.coord_x;
				shape_y[r.vertex_index] = r.coord_y;
				if (r.last_vertex) shape_count = int'(r.vertex_index) + 1;
				a.result_kind = KIND_ACK;
			end
			OP_SUPPORT: begin
				dx = longint'(r.coord_x);
				dy = longint'(r.coord_y);
				best = longint'(shape_x[0]) * dx + longint'(shape_y[0]) * dy;
				for (i = 1; i < n; i++) begin
					dot = longint'(shape_x[i]) * dx + longint'(shape_y[i]) * dy;
					if (dot > best) begin
						best = dot;
						a.support_index = INDEX_BITS'(i);
					end
				end
				a.result_kind = KIND_SUPPORT;
				a.low_x = shape_x[a.support_index];
				a.low_y = shape_y[a.support_index];
			end
			default: begin
				rc = longint'(r.rot_cos);
				rs = longint'(r.rot_sin);
				lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
				for (i = 0; i < n; i++) begin
					px = longint'(shape_x[i]);
					py = longint'(shape_y[i]);
					vx = longint'(clamp_coord(((rc * px - rs * py + ROUND_HALF) >>> ROT_FRAC)
						+ longint'(r.shift_x)));
					vy = longint'(clamp_coord(((rs * px + rc * py + ROUND_HALF) >>> ROT_FRAC)
						+ longint'(r.shift_y)));
					if (i == 0 || vx < lo_x) lo_x = vx;
					if (i == 0 || vy < lo_y) lo_y = vy;
					if (i == 0 || vx > hi_x) hi_x = vx;
					if (i == 0 || vy > hi_y) hi_y = vy;
				end
				a.result_kind = KIND_BOUNDS;
				a.low_x  = COORD_BITS'(lo_x);
				a.low_y  = COORD_BITS'(lo_y);
				a.high_x = COORD_BITS'(hi_x);
				a.high_y = COORD_BITS'(hi_y);
			end
		endcase
		return a;
	endfunction

	function automatic psb_req_t req_of(
		input op_t                          op,
		input logic [INDEX_BITS-1:0]        idx,
		input logic                         last,
		input logic signed [COORD_BITS-1:0] cx,
		input logic signed [COORD_BITS-1:0] cy,
		input logic signed [ROT_BITS-1:0]   rc,
		input logic signed [ROT_BITS-1:0]   rs,
		input logic signed [COORD_BITS-1:0] tx,
		input logic signed [COORD_BITS-1:0] ty
	);
		psb_req_t r;
		r.op           = op;
		r.vertex_index = idx;
		r.last_vertex  = last;
		r.coord_x      = cx;
		r.coord_y      = cy;
		r.rot_cos      = rc;
		r.rot_sin      = rs;
		r.shift_x      = tx;
		r.shift_y      = ty;
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		logic signed [COORD_BITS-1:0] v;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0:       v = COORD_LO;
					1:       v = COORD_HI;
					2:       v = '0;
					default: v = '1;
				endcase
			end
			1, 2, 3: v = COORD_BITS'(int'($urandom_range(16383)) - 8192);
			4, 5:    v = COORD_BITS'(int'($urandom_range(1 << 19)) - (1 << 18));
			default: v = COORD_BITS'($urandom());
		endcase
		return v;
	endfunction

	function automatic logic signed [ROT_BITS-1:0] rand_rot();
		logic signed [ROT_BITS-1:0] v;
		case ($urandom_range(5))
			0:       v = ROT_BITS'(ROT_ONE);
			1:       v = ROT_BITS'(-ROT_ONE);
			2:       v = '0;
			default: v = ROT_BITS'(int'($urandom_range(2 * ROT_ONE)) - ROT_ONE);
		endcase
		return v;
	endfunction

	function automatic psb_req_t random_query();
		logic signed [COORD_BITS-1:0] dx, dy, k;
		op_t                          op;
		op = $urandom_range(1) ? OP_SUPPORT : OP_BOUNDS;
		dx = rand_coord();
		dy = rand_coord();
		if ($urandom_range(3) == 0) begin
			k = rand_coord();
			case ($urandom_range(4))
				0:       begin dx = k;  dy = '0; end
				1:       begin dx = '0; dy = k;  end
				2:       begin dx = k;  dy = k;  end
				3:       begin dx = k;  dy = -k; end
				default: begin dx = '0; dy = '0; end
			endcase
		end
		return req_of(op, INDEX_BITS'($urandom_range(7)), 1'($urandom_range(1)), dx, dy,
			rand_rot(), rand_rot(), rand_coord(), rand_coord());
	endfunction

	function automatic psb_req_t random_write(
		input logic [INDEX_BITS-1:0]        idx,
		input logic                         last,
		input logic signed [COORD_BITS-1:0] cx,
		input logic signed [COORD_BITS-1:0] cy
	);
		return req_of(OP_VERTEX, idx, last, cx, cy, rand_rot(), rand_rot(),
			rand_coord(), rand_coord());
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && req_ready) begin
				replies_owed.push_back(reply_for(req));
				sent_count <= sent_count + 1;
			end
			if (!req_valid || req_ready) begin
				if (requests_to_send.size() != 0 &&
					(steady || $urandom_range(99) >= IDLE_PERCENT)) begin
					req_valid <= 1'b1;
					req       <= requests_to_send.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (!hold_done && sent_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
		end
	end

	always @(posedge clk) begin : check_replies
		psb_rsp_t want;
		bit       unowed;
		if (arst_n && rsp_valid && rsp_ready) begin
			unowed = replies_owed.size() == 0;
			want   = unowed ? psb_rsp_t'('0) : replies_owed.pop_front();
			if (unowed ||
				rsp.result_kind   !== want.result_kind   ||
				rsp.support_index !== want.support_index ||
				rsp.low_x         !== want.low_x         ||
				rsp.low_y         !== want.low_y         ||
				rsp.high_x        !== want.high_x        ||
				rsp.high_y        !== want.high_y) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("%0t reply mismatch%s", $realtime,
						unowed ? " (nothing owed)" : "");
					$display("  expected kind %0d idx %0d low (%0d,%0d) high (%0d,%0d)",
						want.result_kind, want.support_index, want.low_x, want.low_y,
						want.high_x, want.high_y);
					$display("  got      kind %0d idx %0d low (%0d,%0d) high (%0d,%0d)",
						rsp.result_kind, rsp.support_index, rsp.low_x, rsp.low_y,
						rsp.high_x, rsp.high_y);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int                           pick;
		int                           n;
		int                           i;
		bit                           timed_out;
		logic signed [COORD_BITS-1:0] vx, vy;

		// Reset table: box of half size 4096
		requests_to_send.push_back(req_of(OP_SUPPORT, 0, 0, 1, 1, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_BOUNDS, 0, 0, 0, 0, ROT_ONE, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_SUPPORT, 0, 0, 0, 0, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_SUPPORT, 0, 0, -256, 0, 0, 0, 0, 0));
		// Box negation saturates; bounds saturate both ways
		requests_to_send.push_back(req_of(OP_BOX, 0, 0, COORD_LO, COORD_HI, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_BOUNDS, 0, 0, 0, 0, ROT_ONE, 0,
			COORD_HI, COORD_HI));
		requests_to_send.push_back(req_of(OP_BOUNDS, 0, 0, 0, 0, -ROT_ONE, ROT_ONE,
			COORD_LO, COORD_LO));
		requests_to_send.push_back(req_of(OP_SUPPORT, 0, 0, COORD_HI, COORD_LO, 0, 0, 0, 0));
		// Degenerate box: every support direction ties
		requests_to_send.push_back(req_of(OP_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_SUPPORT, 0, 0, 5, 5, 0, 0, 0, 0));
		// Single vertex, then count raised over stale and unwritten slots
		requests_to_send.push_back(req_of(OP_VERTEX, 0, 1, COORD_HI, COORD_LO, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_SUPPORT, 0, 0, -7, 3, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_BOUNDS, 0, 0, 0, 0, ROT_ONE, -ROT_ONE, -1, 1));
		requests_to_send.push_back(req_of(OP_VERTEX, 7, 1, COORD_LO, COORD_HI, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_SUPPORT, 0, 0, -1, 1, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_BOUNDS, 0, 0, 0, 0, 11585, 11585, -3, 5));
		requests_to_send.push_back(req_of(OP_VERTEX, 5, 0, 1000, -2000, 0, 0, 0, 0));
		// Half-way rounding ties on a small triangle
		requests_to_send.push_back(req_of(OP_VERTEX, 0, 0, 1, -1, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_VERTEX, 1, 0, -1, 1, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_VERTEX, 2, 1, 3, -3, 0, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_BOUNDS, 0, 0, 0, 0, 8192, 0, 0, 0));
		requests_to_send.push_back(req_of(OP_BOUNDS, 0, 0, 0, 0, -8192, 8192, 0, 0));
		requests_to_send.push_back(req_of(OP_SUPPORT, 0, 0, 1, -1, 0, 0, 0, 0));

		while (requests_to_send.size() < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				requests_to_send.push_back(req_of(OP_BOX, INDEX_BITS'($urandom_range(7)),
					1'($urandom_range(1)), rand_coord(), rand_coord(), rand_rot(),
					rand_rot(), rand_coord(), rand_coord()));
				repeat ($urandom_range(1, 4)) requests_to_send.push_back(random_query());
			end else if (pick < 65) begin
				n  = $urandom_range(1, MAX_CORNERS_DEF);
				vx = rand_coord();
				vy = rand_coord();
				for (i = 0; i < n; i++) begin
					if (i == 0 || $urandom_range(4) != 0) begin
						vx = rand_coord();
						vy = rand_coord();
					end
					requests_to_send.push_back(random_write(INDEX_BITS'(i),
						i == n - 1, vx, vy));
				end
				repeat ($urandom_range(2, 5)) requests_to_send.push_back(random_query());
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 3)) requests_to_send.push_back(random_query());
			end else begin
				requests_to_send.push_back(random_write(INDEX_BITS'($urandom_range(7)),
					1'($urandom_range(1)), rand_coord(), rand_coord()));
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		timed_out = 1'b0;
		while (!timed_out &&
			!(requests_to_send.size() == 0 && !req_valid && replies_owed.size() == 0)) begin
			@(negedge clk);
			if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
		end
		if (!timed_out) repeat (DRAIN_CYCLES) @(negedge clk);

		if (!timed_out && mismatch_count == 0 && replies_owed.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/psb_pkg.sv
hw/rtl/polygon_support_and_bounds.sv
bench/testbench.sv
